// ===== rtl/core/lcgtx_pkg.sv =====
// ----------------------------------------------------------------------------
// lcgtx_pkg
// Shared types, constants and helpers for the LCG table XOR stream cipher.
// ----------------------------------------------------------------------------
package lcgtx_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 256;

    localparam logic [31:0] LCG_MUL   = 32'h41C6_4E6D;
    localparam logic [31:0] LCG_ADD   = 32'h0000_3039;
    localparam int unsigned INDEX_B_START = 32'h67;
    localparam int unsigned INDEX_WRAP    = 32'hF9;
    localparam int unsigned ENTRY_W       = 31;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_in_message;
    } cipher_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_out;
    } cipher_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUILD_A,
        ST_BUILD_B,
        ST_READ,
        ST_WRITE
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic seed_we;
        logic load_seed;
        logic step_a;
        logic step_b;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic build_done;
        logic last_flag;
    } dp_status_t;

    function automatic logic [31:0] lcg_next(input logic [31:0] x);
        lcg_next = x * LCG_MUL + LCG_ADD;
    endfunction

endpackage

// ===== rtl/core/lcgtx_ctrl.sv =====
// ----------------------------------------------------------------------------
// lcgtx_ctrl
// Sequencer: table rebuild, per-byte read-modify-write and output beat.
// ----------------------------------------------------------------------------
module lcgtx_ctrl
    import lcgtx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic        stale_reg, stale_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            stale_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stale_reg     <= stale_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != ST_IDLE);
        cfg_ready  = (state_reg == ST_IDLE) && !in_valid;

        cmd.seed_we = cfg_valid && cfg_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (stale_reg)
                    begin
                        cmd.load_seed = 1'b1;
                        state_next    = ST_BUILD_A;
                    end
                    else
                    begin
                        // read data was captured at this edge
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_BUILD_A:
            begin
                cmd.step_a = 1'b1;
                state_next = ST_BUILD_B;
            end
            ST_BUILD_B:
            begin
                cmd.step_b = 1'b1;
                state_next = status.build_done ? ST_READ : ST_BUILD_A;
            end
            ST_READ:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.seed_we)
            stale_next = 1'b1;
        else if (cmd.load_seed)
            stale_next = 1'b0;
        else if (cmd.commit && status.last_flag)
            stale_next = 1'b1;
        else
            stale_next = stale_reg;
    end

    assign out_valid_next = cmd.commit | (out_valid_reg & out_stall);
    assign out_valid      = out_valid_reg;

endmodule

// ===== rtl/core/lcgtx_dp.sv =====
// ----------------------------------------------------------------------------
// lcgtx_dp
// Datapath: seed and LCG registers, key table memory, indices, output beat.
// ----------------------------------------------------------------------------
module lcgtx_dp
    import lcgtx_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_status_t  status,
    input  cipher_in_t  in_item,
    input  logic [31:0] cfg_data,
    output cipher_out_t out_item
);

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [31:0]        seed_reg;
    logic [31:0]        lcg_reg, lcg_next_val;
    logic [15:0]        a_hi_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [IDX_W-1:0]   ia_reg, ib_reg, ia_next, ib_next;
    logic [ENTRY_W-1:0] key_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] rd_a_reg, rd_b_reg;
    logic [ENTRY_W-1:0] new_entry, build_entry;
    cipher_in_t         in_reg;
    cipher_out_t        out_reg;

    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx);
        logic [IDX_W:0] n;
        n = {1'b0, idx} + (IDX_W+1)'(1);
        advance = (n >= (IDX_W+1)'(INDEX_WRAP)) ? '0 : n[IDX_W-1:0];
    endfunction

    assign lcg_next_val = lcg_next(lcg_reg);
    assign build_entry  = {lcg_next_val[30:16], a_hi_reg};
    assign new_entry    = rd_a_reg ^ rd_b_reg;
    assign ia_next      = advance(ia_reg);
    assign ib_next      = advance(ib_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            ia_reg   <= '0;
            ib_reg   <= IDX_W'(INDEX_B_START);
            cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.seed_we)
                seed_reg <= cfg_data;
            if (cmd.load_seed)
            begin
                ia_reg  <= '0;
                ib_reg  <= IDX_W'(INDEX_B_START);
                cnt_reg <= '0;
            end
            else
            begin
                if (cmd.step_b)
                    cnt_reg <= cnt_reg + CNT_W'(1);
                if (cmd.commit)
                begin
                    ia_reg <= ia_next;
                    ib_reg <= ib_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_seed)
            lcg_reg <= seed_reg;
        else if (cmd.step_a || cmd.step_b)
            lcg_reg <= lcg_next_val;
        if (cmd.step_a)
            a_hi_reg <= lcg_next_val[31:16];
        if (cmd.accept)
            in_reg <= in_item;
        if (cmd.commit)
        begin
            out_reg.out_byte <= in_reg.data_byte ^ new_entry[7:0];
            out_reg.last_out <= in_reg.last_in_message;
        end
    end

    // key table: one write port, two registered read ports read every cycle
    always_ff @(posedge clk)
    begin
        if (cmd.step_b)
            key_mem[cnt_reg[IDX_W-1:0]] <= build_entry;
        else if (cmd.commit)
            key_mem[ia_reg] <= new_entry;
        rd_a_reg <= key_mem[ia_reg];
        rd_b_reg <= key_mem[ib_reg];
    end

    assign status.build_done = (cnt_reg == CNT_W'(TABLE_DEPTH - 1));
    assign status.last_flag  = in_reg.last_in_message;
    assign out_item          = out_reg;

endmodule

// ===== rtl/core/lcg_table_xor_stream_cipher_top.sv =====
// ----------------------------------------------------------------------------
// lcg_table_xor_stream_cipher_top
// Byte stream cipher: key table built from an LCG seed, XOR keystream.
//
//   channel  dir  handshake          beat
//   in       in   in_valid/in_stall  cipher_in_t: data byte, last flag
//   out      out  out_valid/out_stall cipher_out_t: ciphered byte, last flag
//   cfg      in   cfg_valid/cfg_ready 32-bit seed
//
// With a current table a byte is accepted in idle, both table reads captured
// at that edge, and written back into the output register in the write state;
// no new byte is taken until then. A rebuild (first byte after reset, a seed
// write or a last beat) runs one 32x32 LCG multiply per cycle, two per entry.
// Reset is asynchronous; the table needs no clearing pass. A stalled output
// holds the next byte in write-back; input is stalled meanwhile.
// ----------------------------------------------------------------------------
module lcg_table_xor_stream_cipher_top
    import lcgtx_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  cipher_in_t  in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output cipher_out_t out_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    lcgtx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    lcgtx_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_item  (in_item),
        .cfg_data (cfg_data),
        .out_item (out_item)
    );

endmodule
